// ===== src/mccrf_pkg.sv =====
`timescale 1ns / 1ps

package mccrf_pkg;

	// Table geometry.
	localparam int CHANNELS    = 16;
	localparam int CONTROLLERS = 128;
	localparam int LIFE_BITS   = 16;
	localparam int ENTRIES     = CHANNELS * CONTROLLERS;
	localparam int ADDR_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// Largest life count, held in 32 bits so that a full-width life still fits.
	localparam logic [31:0] LIFE_MAX_32 = 32'((64'd1 << LIFE_BITS) - 64'd1);

	// Register reset value.
	localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

	// Command codes.
	localparam logic [1:0] CMD_MESSAGE = 2'd0;
	localparam logic [1:0] CMD_TICK    = 2'd1;
	localparam logic [1:0] CMD_CLEAR   = 2'd2;

	// Status byte decoding.
	localparam logic [7:0] TYPE_MASK = 8'hf0;
	localparam logic [7:0] CHAN_MASK = 8'h0f;
	localparam logic [7:0] CC_TYPE   = 8'hb0;

	// One table entry.
	typedef struct packed {
		logic                 valid;
		logic [6:0]           value;
		logic [LIFE_BITS-1:0] life;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// Table RAM access from the controller.
	typedef struct packed {
		logic              rd_en;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr_en;
		logic [ADDR_W-1:0] wr_addr;
		entry_t            wr_data;
	} mem_req_t;

	// Result word handed to the output register.
	typedef struct packed {
		logic valid;
		logic is_repeat;
	} res_t;

	// Life loaded into an entry: the timeout, saturated to the life field.
	function automatic logic [LIFE_BITS-1:0] load_life(input logic [15:0] t);
		logic [31:0] t32;
		t32 = 32'(t);
		if (t32 > LIFE_MAX_32) begin
			return LIFE_BITS'(LIFE_MAX_32);
		end
		return LIFE_BITS'(t32);
	endfunction

endpackage

// ===== src/mccrf_in_if.sv =====
`timescale 1ns / 1ps

interface mccrf_in_if;
	logic       valid;
	logic       ready;
	logic [1:0] cmd;
	logic [7:0] status_byte;
	logic [6:0] controller_number;
	logic [6:0] controller_value;

	modport source (
		output valid, cmd, status_byte, controller_number, controller_value,
		input  ready
	);

	modport sink (
		input  valid, cmd, status_byte, controller_number, controller_value,
		output ready
	);
endinterface

// ===== src/mccrf_out_if.sv =====
`timescale 1ns / 1ps

interface mccrf_out_if;
	logic valid;
	logic ready;
	logic is_repeat;

	modport source (
		output valid, is_repeat,
		input  ready
	);

	modport sink (
		input  valid, is_repeat,
		output ready
	);
endinterface

// ===== src/midi_cc_repeat_filter_unit.sv =====
`timescale 1ns / 1ps

// MIDI control-change repeat filter. Every input word yields exactly one result word
// on rsp: a control change on a known channel and controller takes a table read and
// then the write-back that reloads the entry's life; other messages and command code
// 3 need no table access; a tick or a clear sweeps all 2048 entries of the table RAM
// one entry a cycle through its single read and write ports. After reset the block
// clears all 2048 entries before it takes its first word. cfg_we and cfg_wdata write
// timeout_q; the user is to write it only while idle, which the block does not enforce.

module midi_cc_repeat_filter_unit (
	input  logic        clk,
	input  logic        arst_n,
	mccrf_in_if.sink    req,
	mccrf_out_if.source rsp,
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata
);

	import mccrf_pkg::*;

	logic [15:0] timeout_q;
	logic        out_valid_q;
	logic        out_rep_q;
	logic        slot_free;
	mem_req_t    mem;
	res_t        res;
	logic [ENTRY_W-1:0] rd_data;
	entry_t      rd_entry;

	// Timeout register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	// Output register: it holds a finished word until the sink takes it.
	assign slot_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_rep_q   <= 1'b0;
		end else begin
			if (res.valid) begin
				out_valid_q <= 1'b1;
				out_rep_q   <= res.is_repeat;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.is_repeat = out_rep_q;

	// Controller and table.
	mccrf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.slot_free (slot_free),
		.timeout   (timeout_q),
		.rd_entry  (rd_entry),
		.mem       (mem),
		.res       (res)
	);

	assign rd_entry = entry_t'(rd_data);

	mccrf_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (ENTRIES)
	) u_table (
		.clk     (clk),
		.wr_en   (mem.wr_en),
		.wr_addr (mem.wr_addr),
		.wr_data (ENTRY_W'(mem.wr_data)),
		.rd_en   (mem.rd_en),
		.rd_addr (mem.rd_addr),
		.rd_data (rd_data)
	);

	// A new result never lands on a word that is still waiting.
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> slot_free)
		else $error("result overwrote a pending word");

endmodule

// ===== src/mccrf_ram.sv =====
`timescale 1ns / 1ps

module mccrf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                        wr_data,
	input  logic                                    rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                        rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== src/mccrf_ctrl.sv =====
`timescale 1ns / 1ps

module mccrf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	mccrf_in_if.sink          req,
	input  logic              slot_free,
	input  logic [15:0]       timeout,
	input  mccrf_pkg::entry_t rd_entry,
	output mccrf_pkg::mem_req_t mem,
	output mccrf_pkg::res_t   res
);

	import mccrf_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_TICK,
		ST_CLEAR
	} state_t;

	state_t            state_q;
	logic [ADDR_W-1:0] sweep_q;
	logic [ADDR_W-1:0] idx_s1;
	logic [6:0]        value_s1;

	logic              accept;
	logic              is_cc;
	logic              in_range;
	logic              do_lookup;
	logic [ADDR_W-1:0] idx_in;
	logic              sweep_last;
	logic              hit;
	entry_t            aged;

	// Decode of the incoming word.
	always_comb begin
		accept   = req.valid && req.ready;
		is_cc    = (req.status_byte & TYPE_MASK) == CC_TYPE;
		in_range = (32'(req.status_byte & CHAN_MASK) < 32'(CHANNELS))
			&& (32'(req.controller_number) < 32'(CONTROLLERS));
		do_lookup = is_cc && in_range;
		idx_in = ADDR_W'(32'(req.status_byte & CHAN_MASK) * 32'(CONTROLLERS)
			+ 32'(req.controller_number));
	end

	assign req.ready  = (state_q == ST_IDLE) && slot_free;
	assign sweep_last = sweep_q == ADDR_W'(ENTRIES - 1);
	assign hit        = rd_entry.valid && (rd_entry.value == value_s1);

	// Ageing of one entry during a tick sweep.
	always_comb begin
		aged = rd_entry;
		if (rd_entry.valid && (rd_entry.life != '0)) begin
			aged.life = rd_entry.life - LIFE_BITS'(1);
			if (aged.life == '0) begin
				aged.valid = 1'b0;
			end
		end
	end

	// Table accesses and result for the current state.
	always_comb begin
		mem = '0;
		res = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					res.valid = 1'b1;
					unique case (req.cmd)
						CMD_MESSAGE: begin
							if (do_lookup) begin
								mem.rd_en   = 1'b1;
								mem.rd_addr = idx_in;
								res.valid   = 1'b0;
							end
						end
						CMD_TICK: begin
							mem.rd_en   = 1'b1;
							mem.rd_addr = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_LOOKUP: begin
				mem.wr_en         = 1'b1;
				mem.wr_addr       = idx_s1;
				mem.wr_data.valid = 1'b1;
				mem.wr_data.value = value_s1;
				mem.wr_data.life  = load_life(timeout);
				res.valid         = 1'b1;
				res.is_repeat     = hit;
			end
			ST_TICK: begin
				mem.wr_en   = 1'b1;
				mem.wr_addr = sweep_q;
				mem.wr_data = aged;
				if (!sweep_last) begin
					mem.rd_en   = 1'b1;
					mem.rd_addr = sweep_q + ADDR_W'(1);
				end
			end
			ST_CLEAR: begin
				mem.wr_en   = 1'b1;
				mem.wr_addr = sweep_q;
				mem.wr_data = '0;
			end
			default: begin
			end
		endcase
	end

	// Sequencer: reset starts a clearing pass over the whole table.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			sweep_q  <= '0;
			idx_s1   <= '0;
			value_s1 <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (req.cmd)
							CMD_MESSAGE: begin
								if (do_lookup) begin
									state_q  <= ST_LOOKUP;
									idx_s1   <= idx_in;
									value_s1 <= req.controller_value;
								end
							end
							CMD_TICK: begin
								state_q <= ST_TICK;
								sweep_q <= '0;
							end
							CMD_CLEAR: begin
								state_q <= ST_CLEAR;
								sweep_q <= '0;
							end
							default: begin
							end
						endcase
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_IDLE;
				end
				ST_TICK, ST_CLEAR: begin
					if (sweep_last) begin
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + ADDR_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The read and the write of one cycle never meet on the same entry.
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem.rd_en && mem.wr_en) |-> (mem.rd_addr != mem.wr_addr))
		else $error("table read and write collide on one entry");

	// A lookup finishes in the following cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOKUP) |=> (state_q == ST_IDLE))
		else $error("lookup did not return to idle");

	// No write-back is pending while a new word can be taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		req.ready |-> !mem.wr_en)
		else $error("table written while accepting a word");

endmodule
